>>> sv/dq_pkg.sv
// Shared types, constants and helpers for the double-ended queue.
// Used by the controller, the datapath and the port checker.
package dq_pkg;

   // Ring store geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int OP_W        = 3;
   localparam int STS_W       = 2;

   localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] DEPTH_M1  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   // Operation codes; 6 and 7 are unused and ignored
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_LIST_FWD   = 3'd4,
      OP_LIST_BWD   = 3'd5
   } op_type;

   // Result status codes
   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } sts_code_type;

   // Controller to datapath commands
   typedef struct packed {
      logic         push_front;
      logic         push_back;
      logic         pop_front;
      logic         pop_back;
      logic         list_init;
      logic         list_fwd;
      logic         list_step;
      logic         out_load;
      logic         out_use_rd;
      sts_code_type out_status;
      logic         out_last;
   } dq_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic empty;
      logic full;
      logic list_last;
   } dq_sts_type;

   // (base + offset) modulo QUEUE_DEPTH, both operands below QUEUE_DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offset);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

>>> sv/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit words.
// Joins dq_ctrl and dq_dpath; depends on dq_pkg.
//
//   channel  ports                                     role
//   req      req_valid/ready, req_operation, req_value  operation in
//   rsp      rsp_valid/ready, rsp_item/status/last      result words out
//
// Push and pop: the accept edge also does the store write or the registered
// store read, then ST_RESP loads the result word once the output is free.
// A list does one store read to start, then one word per cycle while rsp is
// not stalled, each word's fetch overlapping the previous word's output.
// A new operation is taken once the last word of the previous one sits in the
// output register; reset is synchronous and empties the queue at once.
// A stalled rsp side holds the output word and the list walk in place.
module double_ended_queue
   import dq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_operation,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_item,
   output logic [STS_W-1:0]         rsp_status,
   output logic                     rsp_last
);

   dq_cmd_type cmd;
   dq_sts_type sts;
   logic [DATA_W-1:0] item_raw;

   dq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   dq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_item   (item_raw),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   assign rsp_item = signed'(item_raw);

endmodule

>>> sv/dq_dpath.sv
// Datapath of the double-ended queue: ring store, front pointer, count,
// list walker and result word register. Depends on dq_pkg.
module dq_dpath
   import dq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [DATA_W-1:0] req_value,
   input  dq_cmd_type        cmd,
   output dq_sts_type        sts,
   output logic [DATA_W-1:0] rsp_item,
   output logic [STS_W-1:0]  rsp_status,
   output logic              rsp_last
);

   logic [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] lst_off_ff, lst_off_in;
   logic [CNT_W-1:0] lst_left_ff, lst_left_in;
   logic             lst_fwd_ff, lst_fwd_in;

   logic [DATA_W-1:0] rsp_item_ff;
   logic [STS_W-1:0]  rsp_status_ff;
   logic              rsp_last_ff;

   logic [IDX_W-1:0] count_lo, count_m1, next_off, back_addr;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             rd_en, wr_en;
   logic [CNT_W-1:0] count_dec;

   // Offsets derived from the count; count is nonzero whenever count_m1 is used
   assign count_lo  = count_ff[IDX_W-1:0];
   assign count_dec = count_ff - CNT_W'(1);
   assign count_m1  = count_dec[IDX_W-1:0];
   assign back_addr = ring_add(front_ff, count_m1);
   assign next_off  = lst_fwd_ff ? lst_off_ff + IDX_W'(1) : lst_off_ff - IDX_W'(1);

   // Status to the controller
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == DEPTH_CNT);
   assign sts.list_last = (lst_left_ff == CNT_W'(1));

   // Read address select
   always_comb begin
      rd_en   = cmd.pop_front | cmd.pop_back | cmd.list_init | cmd.list_step;
      rd_addr = ring_add(front_ff, next_off);
      if (cmd.pop_front) begin
         rd_addr = front_ff;
      end else if (cmd.pop_back) begin
         rd_addr = back_addr;
      end else if (cmd.list_init) begin
         rd_addr = cmd.list_fwd ? front_ff : back_addr;
      end
   end

   // Write address select
   always_comb begin
      wr_en   = cmd.push_front | cmd.push_back;
      wr_addr = ring_add(front_ff, count_lo);
      if (cmd.push_front) begin
         wr_addr = ring_add(front_ff, DEPTH_M1);
      end
   end

   // Pointer and count updates
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (cmd.push_front) begin
         front_in = ring_add(front_ff, DEPTH_M1);
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.push_back) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_front) begin
         front_in = ring_add(front_ff, IDX_W'(1));
         count_in = count_dec;
      end else if (cmd.pop_back) begin
         count_in = count_dec;
      end
   end

   // List walker: offset from front and words left to emit
   always_comb begin
      lst_off_in  = lst_off_ff;
      lst_left_in = lst_left_ff;
      lst_fwd_in  = lst_fwd_ff;
      if (cmd.list_init) begin
         lst_fwd_in  = cmd.list_fwd;
         lst_off_in  = cmd.list_fwd ? '0 : count_m1;
         lst_left_in = count_ff;
      end else if (cmd.list_step) begin
         lst_off_in  = next_off;
         lst_left_in = lst_left_ff - CNT_W'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // Walker registers; only meaningful after list_init
   always_ff @(posedge clock) begin
      lst_off_ff  <= lst_off_in;
      lst_left_ff <= lst_left_in;
      lst_fwd_ff  <= lst_fwd_in;
   end

   // Ring store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_item_ff   <= cmd.out_use_rd ? rd_data_ff : '0;
         rsp_status_ff <= cmd.out_status;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_item   = rsp_item_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> sv/dq_ctrl.sv
// Controller of the double-ended queue: request decode, sequencing of
// single results and list walks, result valid. Depends on dq_pkg.
module dq_ctrl
   import dq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_operation,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  dq_sts_type      sts,
   output dq_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESP,
      ST_LIST
   } state_type;

   state_type    state_ff;
   logic         rsp_valid_ff;
   sts_code_type pend_status_ff;
   logic         pend_use_rd_ff;

   logic   accept, out_free;
   op_type op;

   assign op        = op_type'(req_operation);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Commands to the datapath
   always_comb begin
      cmd = '0;
      cmd.out_status = STS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_PUSH_FRONT: cmd.push_front = ~sts.full;
                  OP_PUSH_BACK:  cmd.push_back  = ~sts.full;
                  OP_POP_FRONT:  cmd.pop_front  = ~sts.empty;
                  OP_POP_BACK:   cmd.pop_back   = ~sts.empty;
                  OP_LIST_FWD: begin
                     cmd.list_init = ~sts.empty;
                     cmd.list_fwd  = 1'b1;
                  end
                  OP_LIST_BWD:   cmd.list_init  = ~sts.empty;
                  default:       cmd.list_init  = 1'b0;
               endcase
            end
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_use_rd = pend_use_rd_ff;
               cmd.out_status = pend_status_ff;
               cmd.out_last   = 1'b1;
            end
         end
         ST_LIST: begin
            // Emit the fetched word and fetch the next in the same cycle
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_use_rd = 1'b1;
               cmd.out_last   = sts.list_last;
               cmd.list_step  = ~sts.list_last;
            end
         end
         default: cmd = '0;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         pend_status_ff <= STS_OK;
         pend_use_rd_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (op)
                     OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        state_ff       <= ST_RESP;
                        pend_status_ff <= sts.full ? STS_FULL : STS_OK;
                        pend_use_rd_ff <= 1'b0;
                     end
                     OP_POP_FRONT, OP_POP_BACK: begin
                        state_ff       <= ST_RESP;
                        pend_status_ff <= sts.empty ? STS_EMPTY : STS_OK;
                        pend_use_rd_ff <= ~sts.empty;
                     end
                     OP_LIST_FWD, OP_LIST_BWD: begin
                        state_ff       <= sts.empty ? ST_RESP : ST_LIST;
                        pend_status_ff <= STS_EMPTY;
                        pend_use_rd_ff <= 1'b0;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_RESP: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_LIST: begin
               if (out_free && sts.list_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> sv/dq_check.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on dq_pkg for the status and operation codes.
module dq_check
   import dq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [OP_W-1:0]          req_operation,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_item,
   input logic [STS_W-1:0]         rsp_status,
   input logic                     rsp_last
);

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // Empty and full results are single zero words
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_last && rsp_item == '0)
      else $error("empty/full result not a single zero word");

   // No result word straight out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A valid operation keeps the request side busy for the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation <= OP_LIST_BWD
         |=> !req_ready)
      else $error("request taken back to back");

endmodule

bind double_ended_queue dq_check u_chk (.*);
